// File: rtl/core/i2cms_pkg.sv
// Package for the I2C master bit sequencer: transaction payload types,
// command codes and the per-command step counts. No dependencies.
package i2cms_pkg;

    localparam int unsigned CFG_W = 16;
    localparam logic [CFG_W-1:0] STEP_TICKS_RST = 16'd100;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_STOP     = 3'd1;
    localparam logic [2:0] MODE_SEND     = 3'd2;
    localparam logic [2:0] MODE_RECV     = 3'd3;
    localparam logic [2:0] MODE_SEND_ACK = 3'd4;
    localparam logic [2:0] MODE_RECV_ACK = 3'd5;
    localparam logic [2:0] MODE_LIMIT    = 3'd6;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } out_t;

    // Bit position and phase inside a three-step clock pulse.
    typedef struct packed {
        logic [2:0] bit_idx;
        logic [1:0] phase;
    } pulse_pos_t;

    // Number of steps in each command.
    function automatic logic [4:0] seq_len(input logic [2:0] mode);
        logic [4:0] len;
        case (mode)
            MODE_START:    len = 5'd4;
            MODE_STOP:     len = 5'd3;
            MODE_SEND:     len = 5'd24;
            MODE_RECV:     len = 5'd25;
            MODE_SEND_ACK: len = 5'd3;
            MODE_RECV_ACK: len = 5'd4;
            default:       len = 5'd4;
        endcase
        return len;
    endfunction

    // s / 3 as (s * 11) >> 5, exact for s below 32.
    function automatic pulse_pos_t pulse_pos(input logic [4:0] s);
        logic [8:0] prod;
        logic [3:0] quo;
        logic [5:0] three_q;
        pulse_pos_t pos;
        prod    = {4'd0, s} * 9'd11;
        quo     = prod[8:5];
        three_q = {quo, 1'b0} + {2'd0, quo};
        pos.bit_idx = quo[2:0];
        pos.phase   = 2'({1'b0, s} - three_q);
        return pos;
    endfunction

endpackage

// File: rtl/core/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: tick-driven SCL/SDA step engine.
// Depends on i2cms_pkg.
//
// Each input transaction is one timing tick and yields exactly one result
// transaction carrying the pin levels, busy/done flags and received data
// after that tick. A tick is accepted every clock cycle as long as the
// result register is empty or being drained, so throughput is one tick per
// cycle; each result is registered. Commands (start, stop, send byte, receive
// byte, send ack, receive ack) run as fixed step lists, each step held for
// step_ticks ticks (0 behaves as 1); requests made while busy are dropped.
// step_ticks is written through cfg_we/cfg_wdata and resets to 100.
module i2c_master_bit_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [i2cms_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  i2cms_pkg::in_t              s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output i2cms_pkg::out_t             m_data
);

    logic [i2cms_pkg::CFG_W-1:0] step_ticks_reg;
    logic                        running_reg, running_next;
    logic [2:0]                  mode_reg, mode_next;
    logic [4:0]                  step_reg, step_next;
    logic [15:0]                 hold_reg, hold_next;
    logic [7:0]                  tx_reg, tx_next;
    logic [7:0]                  rx_reg, rx_next;
    logic                        ack_reg, ack_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;
    logic                        done_next;
    logic                        m_valid_reg;
    i2cms_pkg::out_t             m_data_reg;
    i2cms_pkg::pulse_pos_t       pos_s, pos_t;
    logic [15:0]                 limit;
    logic [15:0]                 hold_inc;
    logic [4:0]                  step_inc;
    logic                        accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign limit = (step_ticks_reg == '0) ? 16'd1 : step_ticks_reg;

    always_comb begin
        running_next = running_reg;
        mode_next    = mode_reg;
        step_next    = step_reg;
        hold_next    = hold_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        ack_next     = ack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done_next    = 1'b0;

        if (!running_reg && s_data.cmd_valid && s_data.mode < i2cms_pkg::MODE_LIMIT) begin
            running_next = 1'b1;
            mode_next    = s_data.mode;
            step_next    = '0;
            hold_next    = '0;
            if (s_data.mode == i2cms_pkg::MODE_SEND) begin
                tx_next = s_data.tx_byte;
            end else if (s_data.mode == i2cms_pkg::MODE_SEND_ACK) begin
                tx_next = s_data.ack_out ? i2cms_pkg::MSB_MASK : 8'd0;
            end else if (s_data.mode == i2cms_pkg::MODE_RECV) begin
                rx_next = '0;
            end
        end

        pos_s = i2cms_pkg::pulse_pos(step_next);
        // receive byte pulses start one step later, after SDA release
        pos_t = i2cms_pkg::pulse_pos(step_next - 5'd1);

        if (running_next) begin
            if (hold_next == '0) begin
                case (mode_next)
                    i2cms_pkg::MODE_START: begin
                        case (step_next)
                            5'd0:    sda_next = 1'b1;
                            5'd1:    scl_next = 1'b1;
                            5'd2:    sda_next = 1'b0;
                            default: scl_next = 1'b0;
                        endcase
                    end
                    i2cms_pkg::MODE_STOP: begin
                        case (step_next)
                            5'd0:    sda_next = 1'b0;
                            5'd1:    scl_next = 1'b1;
                            default: sda_next = 1'b1;
                        endcase
                    end
                    i2cms_pkg::MODE_SEND, i2cms_pkg::MODE_SEND_ACK: begin
                        case (pos_s.phase)
                            2'd0:    sda_next = |(tx_next & (i2cms_pkg::MSB_MASK >> pos_s.bit_idx));
                            2'd1:    scl_next = 1'b1;
                            default: scl_next = 1'b0;
                        endcase
                    end
                    i2cms_pkg::MODE_RECV: begin
                        if (step_next == '0) begin
                            sda_next = 1'b1;
                        end else begin
                            case (pos_t.phase)
                                2'd0: scl_next = 1'b1;
                                2'd1: begin
                                    if (s_data.sda_in) begin
                                        rx_next = rx_next | (i2cms_pkg::MSB_MASK >> pos_t.bit_idx);
                                    end
                                end
                                default: scl_next = 1'b0;
                            endcase
                        end
                    end
                    default: begin
                        case (step_next)
                            5'd0:    sda_next = 1'b1;
                            5'd1:    scl_next = 1'b1;
                            5'd2:    ack_next = s_data.sda_in;
                            default: scl_next = 1'b0;
                        endcase
                    end
                endcase
            end

            hold_inc  = hold_next + 16'd1;
            step_inc  = step_next + 5'd1;
            hold_next = hold_inc;
            if (hold_inc >= limit) begin
                hold_next = '0;
                step_next = step_inc;
                if (step_inc >= i2cms_pkg::seq_len(mode_next)) begin
                    running_next = 1'b0;
                    step_next    = '0;
                    done_next    = 1'b1;
                end
            end
        end else begin
            hold_inc = hold_next;
            step_inc = step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ticks_reg <= i2cms_pkg::STEP_TICKS_RST;
        end else if (cfg_we) begin
            step_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            mode_reg    <= '0;
            step_reg    <= '0;
            hold_reg    <= '0;
            tx_reg      <= '0;
            rx_reg      <= '0;
            ack_reg     <= 1'b1;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end else if (accept) begin
            running_reg <= running_next;
            mode_reg    <= mode_next;
            step_reg    <= step_next;
            hold_reg    <= hold_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            ack_reg     <= ack_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with every accepted tick
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.scl_level <= scl_next;
            m_data_reg.sda_level <= sda_next;
            m_data_reg.busy_res  <= running_next;
            m_data_reg.done_res  <= done_next;
            m_data_reg.rx_byte   <= rx_next;
            m_data_reg.ack_in    <= ack_next;
        end
    end

endmodule

// File: tb/tb_i2c_master_bit_sequencer.sv
// Testbench for i2c_master_bit_sequencer: random and directed ticks checked
// against an in-bench model of the SCL/SDA step sequencer.
// Depends on i2cms_pkg and the i2c_master_bit_sequencer RTL.
module tb_i2c_master_bit_sequencer;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_BATCH    = 32;
    localparam int RANDOM_TICKS   = 210;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [i2cms_pkg::CFG_W-1:0]  cfg_wdata = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    i2cms_pkg::in_t               s_data = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    i2cms_pkg::out_t              m_data;

    i2c_master_bit_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    // Sequencer model state
    logic [15:0] step_ticks_q = i2cms_pkg::STEP_TICKS_RST;
    logic        seq_running = 1'b0;
    logic [2:0]  seq_mode = i2cms_pkg::MODE_START;
    logic [4:0]  seq_step = '0;
    logic [15:0] seq_hold = '0;
    logic [7:0]  tx_sr = '0;
    logic [7:0]  rx_sr = '0;
    logic        ack_smp = 1'b1;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;

    i2cms_pkg::in_t  tick_queue[$];
    i2cms_pkg::out_t line_states[$];

    int   mismatch_count = 0;
    int   cycle_cnt = 0;
    int   idle_cycles = 0;
    int   holdoff_left = 0;
    bit   holdoff_done = 1'b0;
    bit   flood_armed = 1'b0;
    logic in_taken = 1'b0;
    logic calm;

    assign calm = (cycle_cnt >= 1500) && (cycle_cnt < 2100);

    function automatic logic [4:0] command_steps(input logic [2:0] m);
        case (m)
            i2cms_pkg::MODE_START:    return 5'd4;
            i2cms_pkg::MODE_STOP:     return 5'd3;
            i2cms_pkg::MODE_SEND:     return 5'd24;
            i2cms_pkg::MODE_RECV:     return 5'd25;
            i2cms_pkg::MODE_SEND_ACK: return 5'd3;
            default:                  return 5'd4;
        endcase
    endfunction

    // Pin action taken on the first tick of step s of the running command.
    function automatic void step_action(input logic [4:0] s, input logic sda);
        int k;
        int bitn;
        int ph;
        k = int'(s);
        case (seq_mode)
            i2cms_pkg::MODE_START: begin
                case (k)
                    0: sda_q = 1'b1;
                    1: scl_q = 1'b1;
                    2: sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end
            i2cms_pkg::MODE_STOP: begin
                case (k)
                    0: sda_q = 1'b0;
                    1: scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            end
            i2cms_pkg::MODE_SEND, i2cms_pkg::MODE_SEND_ACK: begin
                bitn = (k / 3) % 8;
                ph = k % 3;
                if (ph == 0) sda_q = tx_sr[7 - bitn];
                else if (ph == 1) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            i2cms_pkg::MODE_RECV: begin
                if (k == 0) begin
                    sda_q = 1'b1;
                end else begin
                    bitn = ((k - 1) / 3) % 8;
                    ph = (k - 1) % 3;
                    if (ph == 0) scl_q = 1'b1;
                    else if (ph == 1) begin
                        if (sda) rx_sr[7 - bitn] = 1'b1;
                    end else scl_q = 1'b0;
                end
            end
            default: begin
                case (k)
                    0: sda_q = 1'b1;
                    1: scl_q = 1'b1;
                    2: ack_smp = sda;
                    default: scl_q = 1'b0;
                endcase
            end
        endcase
    endfunction

    // Advance the model by one tick and return the line state after it.
    function automatic i2cms_pkg::out_t line_tick(input i2cms_pkg::in_t tk);
        i2cms_pkg::out_t r;
        logic [16:0] lim;
        logic [16:0] nxt;
        logic done;
        done = 1'b0;
        lim = (step_ticks_q == '0) ? 17'd1 : {1'b0, step_ticks_q};
        if (!seq_running && tk.cmd_valid && tk.mode < i2cms_pkg::MODE_LIMIT) begin
            seq_running = 1'b1;
            seq_mode = tk.mode;
            seq_step = '0;
            seq_hold = '0;
            if (tk.mode == i2cms_pkg::MODE_SEND) tx_sr = tk.tx_byte;
            else if (tk.mode == i2cms_pkg::MODE_SEND_ACK)
                tx_sr = tk.ack_out ? i2cms_pkg::MSB_MASK : 8'h00;
            else if (tk.mode == i2cms_pkg::MODE_RECV) rx_sr = '0;
        end
        if (seq_running) begin
            if (seq_hold == '0) step_action(seq_step, tk.sda_in);
            nxt = {1'b0, seq_hold} + 17'd1;
            if (nxt >= lim) begin
                seq_hold = '0;
                seq_step = seq_step + 5'd1;
                if (seq_step >= command_steps(seq_mode)) begin
                    seq_running = 1'b0;
                    seq_step = '0;
                    done = 1'b1;
                end
            end else begin
                seq_hold = nxt[15:0];
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = seq_running;
        r.done_res  = done;
        r.rx_byte   = rx_sr;
        r.ack_in    = ack_smp;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor: model runs on each accepted tick, results checked in order.
    always @(posedge aclk) begin : monitor
        i2cms_pkg::out_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (line_states.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatch_count++;
                end else begin
                    want = line_states.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(m_data.scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(m_data.sda_level));
                    check_field("busy_res", 8'(want.busy_res), 8'(m_data.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(m_data.done_res));
                    check_field("rx_byte", want.rx_byte, m_data.rx_byte);
                    check_field("ack_in", 8'(want.ack_in), 8'(m_data.ack_in));
                end
            end
            if (s_valid && s_ready) line_states.push_back(line_tick(s_data));
        end
    end

    // Tick driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (tick_queue.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
                s_valid <= 1'b1;
                s_data <= tick_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off once the random part is queued
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && flood_armed && tick_queue.size() > 50) begin
            m_ready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_i2c_master_bit_sequencer NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_tick(input bit v, input logic [2:0] m, input logic [7:0] b,
                             input bit a, input bit d);
        i2cms_pkg::in_t tk;
        tk.cmd_valid = v;
        tk.mode = m;
        tk.tx_byte = b;
        tk.ack_out = a;
        tk.sda_in = d;
        tick_queue.push_back(tk);
    endtask

    // n ticks with no request; sda < 0 means random SDA
    task automatic push_idle(input int n, input int sda);
        for (int i = 0; i < n; i++)
            push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), (sda < 0) ? 1'($urandom_range(1)) : 1'(sda));
    endtask

    // Wait for all results, then run out any command still in progress.
    task automatic settle();
        bit busy;
        busy = 1'b1;
        while (busy) begin
            while (tick_queue.size() > 0 || s_valid || line_states.size() > 0)
                @(posedge aclk);
            if (seq_running) push_idle(DRAIN_BATCH, -1);
            else busy = 1'b0;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step_ticks(input logic [15:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        step_ticks_q = v;
    endtask

    logic [15:0] phase_ticks[6] = '{16'd0, 16'd2, 16'd1, 16'd3, 16'd5, 16'd1};

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of step_ticks
        push_tick(1'b1, i2cms_pkg::MODE_START, 8'h00, 1'b0, 1'b1);
        push_idle(3, -1);
        push_tick(1'b1, i2cms_pkg::MODE_RECV_ACK, 8'h00, 1'b0, 1'b0);
        settle();

        write_step_ticks(16'd1);
        // undefined modes are dropped
        push_tick(1'b1, i2cms_pkg::MODE_LIMIT, 8'h5A, 1'b1, 1'b0);
        push_tick(1'b1, i2cms_pkg::MODE_LIMIT + 3'd1, 8'hA5, 1'b0, 1'b1);
        push_idle(1, -1);
        // request on the finish tick is dropped, the next one starts
        push_tick(1'b1, i2cms_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
        push_idle(2, -1);
        push_tick(1'b1, i2cms_pkg::MODE_STOP, 8'h00, 1'b0, 1'b1);
        push_tick(1'b1, i2cms_pkg::MODE_STOP, 8'h00, 1'b0, 1'b0);
        push_idle(3, -1);
        push_tick(1'b1, i2cms_pkg::MODE_SEND, 8'hFF, 1'b0, 1'b0);
        push_idle(25, -1);
        push_tick(1'b1, i2cms_pkg::MODE_SEND, 8'h00, 1'b1, 1'b1);
        push_idle(25, -1);
        push_tick(1'b1, i2cms_pkg::MODE_SEND, 8'hA5, 1'b0, 1'b0);
        push_idle(5, -1);
        push_tick(1'b1, i2cms_pkg::MODE_RECV, 8'h00, 1'b0, 1'b1);
        push_idle(20, -1);
        push_tick(1'b1, i2cms_pkg::MODE_RECV, 8'h00, 1'b0, 1'b1);
        push_idle(26, 1);
        push_tick(1'b1, i2cms_pkg::MODE_RECV, 8'h00, 1'b0, 1'b0);
        push_idle(26, 0);
        push_tick(1'b1, i2cms_pkg::MODE_RECV, 8'h00, 1'b0, 1'b1);
        push_idle(26, -1);
        push_tick(1'b1, i2cms_pkg::MODE_SEND_ACK, 8'h00, 1'b0, 1'b1);
        push_idle(3, -1);
        push_tick(1'b1, i2cms_pkg::MODE_SEND_ACK, 8'h00, 1'b1, 1'b0);
        push_idle(3, -1);
        push_tick(1'b1, i2cms_pkg::MODE_RECV_ACK, 8'h00, 1'b0, 1'b0);
        push_idle(4, 0);
        push_tick(1'b1, i2cms_pkg::MODE_RECV_ACK, 8'h00, 1'b0, 1'b1);
        push_idle(4, 1);
        settle();

        // random ticks over several step lengths, zero among them
        flood_armed = 1'b1;
        foreach (phase_ticks[p]) begin
            write_step_ticks(phase_ticks[p]);
            for (int n = 0; n < RANDOM_TICKS; n++) begin
                if ($urandom_range(19) == 0)
                    push_tick(1'b1, i2cms_pkg::MODE_LIMIT + 3'($urandom_range(1)),
                              8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                else
                    push_tick($urandom_range(99) < 45, 3'($urandom_range(5)),
                              8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("tb_i2c_master_bit_sequencer OK");
        else
            $display("tb_i2c_master_bit_sequencer NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/core/i2cms_pkg.sv
rtl/core/i2c_master_bit_sequencer.sv
tb/tb_i2c_master_bit_sequencer.sv
